// ----- design/rmq_pkg.sv -----
// ----------------------------------------------------------------------------
// rmq_pkg - shared types and constants
// Widths, stage counts and pipeline word formats for the rotation matrix
// to quaternion converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rmq_pkg;

    localparam int DataW      = 16;           // Q2.14 field width
    localparam int RootW      = 16;           // root s width
    localparam int ArgW       = 17;           // clamped root argument width
    localparam int VW         = ArgW + 14;    // argument scaled by 2^14
    localparam int MagW       = 17;           // |sum or difference|
    localparam int RemSqW     = 20;           // root remainder
    localparam int DvsW       = RootW + 1;    // divisor 2s
    localparam int QuotW      = 16;
    localparam int NumW       = DvsW + QuotW; // dividend and remainder
    localparam int SqrtBits   = 2;            // root bits per stage
    localparam int SqrtStages = RootW / SqrtBits;
    localparam int DivBits    = 2;            // quotient bits per stage
    localparam int DivStages  = QuotW / DivBits;
    localparam int QOne       = 16384;

    typedef enum logic [1:0]
    {
        SLOT_X,
        SLOT_Y,
        SLOT_Z,
        SLOT_W
    } slot_t;

    // side information riding along the pipeline
    typedef struct packed
    {
        logic [3:0][MagW-1:0] mag;
        logic [3:0]           neg;
        slot_t                diag;
        logic                 clamp;
    } side_t;

    // digit-by-digit root state
    typedef struct packed
    {
        logic [RemSqW-1:0] rem;
        logic [RootW-1:0]  root;
        logic [VW:0]       vbits;
    } sq_t;

    // restoring divider state, one lane per component
    typedef struct packed
    {
        logic [3:0][NumW-1:0]  rem;
        logic [3:0][QuotW-1:0] quot;
        logic [3:0]            ovf;
        logic [DvsW-1:0]       dvs;
        logic [RootW-1:0]      root;
    } dv_t;

endpackage

`default_nettype wire

// ----- design/rmq_front.sv -----
// ----------------------------------------------------------------------------
// rmq_front - branch selection stage
// Picks the trace or diagonal branch, forms the root argument and the
// element sums and differences, and registers them.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_front
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        in_vld,
    input  wire logic signed [15:0]          xx,
    input  wire logic signed [15:0]          xy,
    input  wire logic signed [15:0]          xz,
    input  wire logic signed [15:0]          yx,
    input  wire logic signed [15:0]          yy,
    input  wire logic signed [15:0]          yz,
    input  wire logic signed [15:0]          zx,
    input  wire logic signed [15:0]          zy,
    input  wire logic signed [15:0]          zz,
    output logic                             out_vld,
    output logic [rmq_pkg::VW-1:0]           v,
    output rmq_pkg::side_t                   side
);
    import rmq_pkg::*;

    logic                 vld_reg;
    logic [VW-1:0]        v_reg;
    side_t                side_reg;
    logic [VW-1:0]        v_next;
    side_t                side_next;

    // branch choice, argument and component sums and differences
    always_comb
    begin
        logic signed [17:0] tr;
        logic signed [18:0] arg;
        logic signed [17:0] d [4];
        logic [17:0]        m;
        logic [ArgW-1:0]    a;
        tr = 18'(xx) + 18'(yy) + 18'(zz);
        d[SLOT_X] = '0;
        d[SLOT_Y] = '0;
        d[SLOT_Z] = '0;
        d[SLOT_W] = '0;
        if (tr > 18'sd0)
        begin
            arg = 19'(tr) + 19'(QOne);
            side_next.diag = SLOT_W;
            d[SLOT_X] = 18'(zy) - 18'(yz);
            d[SLOT_Y] = 18'(xz) - 18'(zx);
            d[SLOT_Z] = 18'(yx) - 18'(xy);
        end
        else if (xx > yy && xx > zz)
        begin
            arg = 19'(xx) - 19'(yy) - 19'(zz) + 19'(QOne);
            side_next.diag = SLOT_X;
            d[SLOT_Y] = 18'(yx) + 18'(xy);
            d[SLOT_Z] = 18'(zx) + 18'(xz);
            d[SLOT_W] = 18'(zy) - 18'(yz);
        end
        else if (yy > xx && yy > zz)
        begin
            arg = 19'(yy) - 19'(xx) - 19'(zz) + 19'(QOne);
            side_next.diag = SLOT_Y;
            d[SLOT_X] = 18'(xy) + 18'(yx);
            d[SLOT_Z] = 18'(zy) + 18'(yz);
            d[SLOT_W] = 18'(xz) - 18'(zx);
        end
        else
        begin
            arg = 19'(zz) - 19'(xx) - 19'(yy) + 19'(QOne);
            side_next.diag = SLOT_Z;
            d[SLOT_X] = 18'(xz) + 18'(zx);
            d[SLOT_Y] = 18'(yz) + 18'(zy);
            d[SLOT_W] = 18'(yx) - 18'(xy);
        end
        // non-positive argument clamps to one LSB
        side_next.clamp = (arg <= 19'sd0);
        a = side_next.clamp ? ArgW'(1) : arg[ArgW-1:0];
        v_next = {a, 14'd0};
        for (int j = 0; j < 4; j++)
        begin
            m = d[j][17] ? 18'(-d[j]) : 18'(d[j]);
            side_next.mag[j] = m[MagW-1:0];
            side_next.neg[j] = d[j][17];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && in_vld)
        begin
            v_reg    <= v_next;
            side_reg <= side_next;
        end
    end

    assign out_vld = vld_reg;
    assign v       = v_reg;
    assign side    = side_reg;

endmodule

`default_nettype wire

// ----- design/rmq_sqrt.sv -----
// ----------------------------------------------------------------------------
// rmq_sqrt - pipelined integer square root
// Digit-by-digit root of the scaled argument, two root bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_sqrt
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        in_vld,
    input  wire logic [rmq_pkg::VW-1:0]      v,
    input  wire rmq_pkg::side_t              in_side,
    output logic                             out_vld,
    output logic [rmq_pkg::RootW-1:0]        root,
    output rmq_pkg::side_t                   out_side
);
    import rmq_pkg::*;

    logic  vld_reg  [SqrtStages];
    sq_t   st_reg   [SqrtStages];
    side_t side_reg [SqrtStages];

    for (genvar k = 0; k < SqrtStages; k++)
    begin : g_stage
        logic  cur_vld;
        sq_t   cur;
        side_t cur_side;
        sq_t   nxt;

        if (k == 0)
        begin : g_first
            assign cur_vld  = in_vld;
            assign cur      = '{rem: '0, root: '0, vbits: {1'b0, v}};
            assign cur_side = in_side;
        end
        else
        begin : g_next
            assign cur_vld  = vld_reg[k-1];
            assign cur      = st_reg[k-1];
            assign cur_side = side_reg[k-1];
        end

        // two trial subtractions
        always_comb
        begin
            logic [RemSqW-1:0] r;
            logic [RootW-1:0]  q;
            logic [VW:0]       b;
            logic [RemSqW-1:0] trial;
            r = cur.rem;
            q = cur.root;
            b = cur.vbits;
            for (int j = 0; j < SqrtBits; j++)
            begin
                r = {r[RemSqW-3:0], b[VW:VW-1]};
                b = {b[VW-2:0], 2'b00};
                trial = RemSqW'({q, 2'b01});
                if (r >= trial)
                begin
                    r = r - trial;
                    q = {q[RootW-2:0], 1'b1};
                end
                else
                begin
                    q = {q[RootW-2:0], 1'b0};
                end
            end
            nxt = '{rem: r, root: q, vbits: b};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= cur_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en && cur_vld)
            begin
                st_reg[k]   <= nxt;
                side_reg[k] <= cur_side;
            end
        end
    end

    assign out_vld  = vld_reg[SqrtStages-1];
    assign root     = st_reg[SqrtStages-1].root;
    assign out_side = side_reg[SqrtStages-1];

endmodule

`default_nettype wire

// ----- design/rmq_div.sv -----
// ----------------------------------------------------------------------------
// rmq_div - pipelined rounding divider
// Four lanes of restoring division of mag*2^14 + s by 2s, giving the
// rounded magnitude of d*0.5/s; two quotient bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_div
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        en,
    input  wire logic                        in_vld,
    input  wire logic [rmq_pkg::RootW-1:0]   root,
    input  wire rmq_pkg::side_t              in_side,
    output logic                             out_vld,
    output rmq_pkg::dv_t                     out_dv,
    output rmq_pkg::side_t                   out_side
);
    import rmq_pkg::*;

    logic  vld_reg  [DivStages];
    dv_t   st_reg   [DivStages];
    side_t side_reg [DivStages];
    dv_t   init;

    // dividend with rounding term, divisor, quotient range check
    always_comb
    begin
        init.root = root;
        init.dvs  = {root, 1'b0};
        for (int m = 0; m < 4; m++)
        begin
            init.rem[m]  = NumW'({in_side.mag[m], 14'd0}) + NumW'(root);
            init.quot[m] = '0;
            init.ovf[m]  = (init.rem[m] >= {init.dvs, QuotW'(0)});
        end
    end

    for (genvar k = 0; k < DivStages; k++)
    begin : g_stage
        logic  cur_vld;
        dv_t   cur;
        side_t cur_side;
        dv_t   nxt;

        if (k == 0)
        begin : g_first
            assign cur_vld  = in_vld;
            assign cur      = init;
            assign cur_side = in_side;
        end
        else
        begin : g_next
            assign cur_vld  = vld_reg[k-1];
            assign cur      = st_reg[k-1];
            assign cur_side = side_reg[k-1];
        end

        // two quotient bits in every lane
        always_comb
        begin
            dv_t             w;
            logic [NumW-1:0] cmp;
            w = cur;
            for (int j = 0; j < DivBits; j++)
            begin
                for (int m = 0; m < 4; m++)
                begin
                    cmp = NumW'(w.dvs) << (QuotW - 1 - k * DivBits - j);
                    if (w.rem[m] >= cmp)
                    begin
                        w.rem[m] = w.rem[m] - cmp;
                        w.quot[m][QuotW-1-k*DivBits-j] = 1'b1;
                    end
                end
            end
            nxt = w;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= cur_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en && cur_vld)
            begin
                st_reg[k]   <= nxt;
                side_reg[k] <= cur_side;
            end
        end
    end

    assign out_vld  = vld_reg[DivStages-1];
    assign out_dv   = st_reg[DivStages-1];
    assign out_side = side_reg[DivStages-1];

endmodule

`default_nettype wire

// ----- design/rotation_matrix_to_quaternion.sv -----
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion - matrix to quaternion converter
// Shepperd's method on signed Q2.14 values, fully pipelined.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall carry one word of nine matrix elements
// (three axis vectors). Output channel: out_valid/out_stall carry one word
// of four quaternion components and the saturated flag.
// A word is taken on any edge with valid high and stall low.
// The pipeline has one branch-select stage, eight root stages (two
// root bits each), eight divider stages (two quotient bits each, four
// lanes sharing the divisor) and the output register.
// Throughput is one word per cycle; the rate is set by the pipeline, which
// accepts a new word every cycle while no stall is held.
// Reset clears every valid bit; no words are in flight afterwards.
// While the receiver holds out_stall with a word waiting, the whole pipeline
// freezes and in_stall is raised in the same cycle; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module rotation_matrix_to_quaternion
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [15:0] x_axis_x,
    input  wire logic signed [15:0] x_axis_y,
    input  wire logic signed [15:0] x_axis_z,
    input  wire logic signed [15:0] y_axis_x,
    input  wire logic signed [15:0] y_axis_y,
    input  wire logic signed [15:0] y_axis_z,
    input  wire logic signed [15:0] z_axis_x,
    input  wire logic signed [15:0] z_axis_y,
    input  wire logic signed [15:0] z_axis_z,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [15:0]      quat_x,
    output logic signed [15:0]      quat_y,
    output logic signed [15:0]      quat_z,
    output logic signed [15:0]      quat_w,
    output logic                    saturated
);
    import rmq_pkg::*;

    logic              en;
    logic              fr_vld;
    logic [VW-1:0]     fr_v;
    side_t             fr_side;
    logic              sq_vld;
    logic [RootW-1:0]  sq_root;
    side_t             sq_side;
    logic              dv_vld;
    dv_t               dv;
    side_t             dv_side;

    logic                    out_vld_reg;
    logic signed [15:0]      q_reg [4];
    logic                    sat_reg;
    slot_t                   diag_reg;
    logic signed [15:0]      q_next [4];
    logic                    sat_next;

    // whole pipeline advances unless a finished word is held
    assign en       = !(out_vld_reg && out_stall);
    assign in_stall = !en;

    rmq_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (in_valid),
        .xx      (x_axis_x),
        .xy      (x_axis_y),
        .xz      (x_axis_z),
        .yx      (y_axis_x),
        .yy      (y_axis_y),
        .yz      (y_axis_z),
        .zx      (z_axis_x),
        .zy      (z_axis_y),
        .zz      (z_axis_z),
        .out_vld (fr_vld),
        .v       (fr_v),
        .side    (fr_side)
    );

    rmq_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (fr_vld),
        .v        (fr_v),
        .in_side  (fr_side),
        .out_vld  (sq_vld),
        .root     (sq_root),
        .out_side (sq_side)
    );

    rmq_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (sq_vld),
        .root     (sq_root),
        .in_side  (sq_side),
        .out_vld  (dv_vld),
        .out_dv   (dv),
        .out_side (dv_side)
    );

    // sign, saturation and the half-root diagonal term
    always_comb
    begin
        logic [16:0] r;
        logic [16:0] half;
        sat_next = dv_side.clamp;
        half     = (17'(dv.root) + 17'd1) >> 1;
        for (int m = 0; m < 4; m++)
        begin
            r = dv.ovf[m] ? 17'h10000 : {1'b0, dv.quot[m]};
            if (dv_side.diag == slot_t'(m))
            begin
                q_next[m] = half[15:0];
            end
            else if (!dv_side.neg[m])
            begin
                if (r > 17'd32767)
                begin
                    q_next[m] = 16'sh7fff;
                    sat_next  = 1'b1;
                end
                else
                begin
                    q_next[m] = r[15:0];
                end
            end
            else
            begin
                if (r > 17'd32768)
                begin
                    q_next[m] = 16'sh8000;
                    sat_next  = 1'b1;
                end
                else
                begin
                    q_next[m] = 16'(~r + 17'd1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= dv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && dv_vld)
        begin
            q_reg    <= q_next;
            sat_reg  <= sat_next;
            diag_reg <= dv_side.diag;
        end
    end

    assign out_valid = out_vld_reg;
    assign quat_x    = q_reg[SLOT_X];
    assign quat_y    = q_reg[SLOT_Y];
    assign quat_z    = q_reg[SLOT_Z];
    assign quat_w    = q_reg[SLOT_W];
    assign saturated = sat_reg;

    // diagonal term is half a root of at least 128 and at most 46340
    a_diag_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (q_reg[diag_reg] >= 16'sd64 && q_reg[diag_reg] <= 16'sd23170))
        else $error("diagonal component out of range");

    // root leaving the square-root pipe is never below 128
    a_root_min: assert property (@(posedge clk) disable iff (!rst_n)
        sq_vld |-> (sq_root >= RootW'(128)))
        else $error("root below minimum");

    // a frozen pipeline keeps all its valid bits
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(fr_vld) && $stable(sq_vld) && $stable(dv_vld)))
        else $error("valid bits moved during stall");

    // a word leaving the divider reaches the output register
    a_deliver: assert property (@(posedge clk) disable iff (!rst_n)
        (en && dv_vld) |=> out_vld_reg)
        else $error("word dropped at output stage");

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb - rotation matrix to quaternion converter testbench
// Drives matrix words with random idling on both channels, predicts each
// quaternion with an integer model of Shepperd's method, and compares every
// output word field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed
    {
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
        logic signed [15:0] qw;
        logic               sat;
    } quat_t;

    typedef struct packed
    {
        logic signed [15:0] xx, xy, xz, yx, yy, yz, zx, zy, zz;
    } matrix_t;

    typedef struct
    {
        matrix_t m;
        bit      known;
        quat_t   q;
    } stim_row_t;

    localparam int NumRandom  = 650;
    localparam int TailCycles = 40;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [15:0] x_axis_x, x_axis_y, x_axis_z;
    logic signed [15:0] y_axis_x, y_axis_y, y_axis_z;
    logic signed [15:0] z_axis_x, z_axis_y, z_axis_z;
    logic               out_valid;
    logic               out_stall;
    logic signed [15:0] quat_x, quat_y, quat_z, quat_w;
    logic               saturated;

    quat_t      quat_expected[$];
    int         fail_count;
    int         words_checked;
    bit         sender_done;
    bit         calm;        // no idling in the last part of the run
    bit         hold_off;    // long receiver hold-off request
    stim_row_t  dir_rows[$];

    rotation_matrix_to_quaternion dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .x_axis_x (x_axis_x),
        .x_axis_y (x_axis_y),
        .x_axis_z (x_axis_z),
        .y_axis_x (y_axis_x),
        .y_axis_y (y_axis_y),
        .y_axis_z (y_axis_z),
        .z_axis_x (z_axis_x),
        .z_axis_y (z_axis_y),
        .z_axis_z (z_axis_z),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .quat_x   (quat_x),
        .quat_y   (quat_y),
        .quat_z   (quat_z),
        .quat_w   (quat_w),
        .saturated(saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // --- quaternion predictor ---------------------------------------------

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        r = 0;
        for (int b = 31; b >= 0; b--)
        begin
            longint unsigned c;
            c = r | (64'd1 << b);
            if (c * c <= v)
                r = c;
        end
        return r;
    endfunction

    function automatic longint clip16(longint v, ref bit sat);
        if (v > 32767)
        begin
            sat = 1'b1;
            return 32767;
        end
        if (v < -32768)
        begin
            sat = 1'b1;
            return -32768;
        end
        return v;
    endfunction

    function automatic longint unsigned root_q(longint a, ref bit sat);
        if (a <= 0)
        begin
            sat = 1'b1;
            a = 1;
        end
        return int_sqrt(longint'(a) * 16384);
    endfunction

    function automatic longint div_by_root(longint d, longint unsigned s, ref bit sat);
        longint unsigned mag;
        longint unsigned q;
        longint r;
        mag = (d < 0) ? -d : d;
        q = (mag * 16384 + s) / (2 * s);
        r = (q > 65536) ? 65536 : longint'(q);
        return clip16(d < 0 ? -r : r, sat);
    endfunction

    function automatic longint half_root(longint unsigned s, ref bit sat);
        return clip16(longint'((s + 1) >> 1), sat);
    endfunction

    function automatic quat_t predict_quat(matrix_t m);
        longint xx, xy, xz, yx, yy, yz, zx, zy, zz, tr;
        longint unsigned s;
        bit sat;
        quat_t q;
        xx = longint'(m.xx); xy = longint'(m.xy); xz = longint'(m.xz);
        yx = longint'(m.yx); yy = longint'(m.yy); yz = longint'(m.yz);
        zx = longint'(m.zx); zy = longint'(m.zy); zz = longint'(m.zz);
        tr = xx + yy + zz;
        sat = 1'b0;
        if (tr > 0)
        begin
            s = root_q(tr + 16384, sat);
            q.qx = 16'(div_by_root(zy - yz, s, sat));
            q.qy = 16'(div_by_root(xz - zx, s, sat));
            q.qz = 16'(div_by_root(yx - xy, s, sat));
            q.qw = 16'(half_root(s, sat));
        end
        else if (xx > yy && xx > zz)
        begin
            s = root_q(xx - yy - zz + 16384, sat);
            q.qx = 16'(half_root(s, sat));
            q.qy = 16'(div_by_root(yx + xy, s, sat));
            q.qz = 16'(div_by_root(zx + xz, s, sat));
            q.qw = 16'(div_by_root(zy - yz, s, sat));
        end
        else if (yy > xx && yy > zz)
        begin
            s = root_q(yy - xx - zz + 16384, sat);
            q.qx = 16'(div_by_root(xy + yx, s, sat));
            q.qy = 16'(half_root(s, sat));
            q.qz = 16'(div_by_root(zy + yz, s, sat));
            q.qw = 16'(div_by_root(xz - zx, s, sat));
        end
        else
        begin
            s = root_q(zz - xx - yy + 16384, sat);
            q.qx = 16'(div_by_root(xz + zx, s, sat));
            q.qy = 16'(div_by_root(yz + zy, s, sat));
            q.qz = 16'(half_root(s, sat));
            q.qw = 16'(div_by_root(yx - xy, s, sat));
        end
        q.sat = sat;
        return q;
    endfunction

    // --- stimulus helpers ---------------------------------------------------

    function automatic logic signed [15:0] rand_elem();
        case ($urandom_range(0, 9))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'sd16384;
            3:       return -16'sd16384;
            4:       return 16'sd0;
            5, 6:    return 16'($urandom_range(0, 32767) - 16384);
            default: return 16'($urandom());
        endcase
    endfunction

    // near-rotation matrix: signed permutation with small noise on each element
    function automatic matrix_t rand_rotation();
        logic signed [15:0] e[9];
        int perm[3];
        int tmp, k;
        perm = '{0, 1, 2};
        for (int i = 2; i > 0; i--)
        begin
            k = $urandom_range(0, i);
            tmp = perm[i]; perm[i] = perm[k]; perm[k] = tmp;
        end
        for (int i = 0; i < 9; i++)
            e[i] = 16'($urandom_range(0, 4000) - 2000);
        for (int r = 0; r < 3; r++)
            e[r * 3 + perm[r]] = 16'(($urandom_range(0, 1) ? 16384 : -16384)
                                     + $urandom_range(0, 2000) - 1000);
        return {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
    endfunction

    function automatic matrix_t diag_matrix(int a, int b, int c);
        matrix_t m;
        m = '0;
        m.xx = 16'(a); m.yy = 16'(b); m.zz = 16'(c);
        return m;
    endfunction

    task automatic add_row(matrix_t m, bit known, quat_t q);
        stim_row_t r;
        r.m = m; r.known = known; r.q = q;
        dir_rows.push_back(r);
    endtask

    // --- directed table -------------------------------------------------------

    task automatic build_table();
        matrix_t m;
        // identity: trace branch, w = 1.0
        add_row(diag_matrix(16384, 16384, 16384), 1, '{0, 0, 0, 16384, 0});
        // all zero: z branch, argument 1.0 gives s = 1.0, z = 0.5
        add_row('0, 1, '{0, 0, 8192, 0, 0});
        // half turn about each axis
        add_row(diag_matrix(16384, -16384, -16384), 1, '{16384, 0, 0, 0, 0});
        add_row(diag_matrix(-16384, 16384, -16384), 1, '{0, 16384, 0, 0, 0});
        add_row(diag_matrix(-16384, -16384, 16384), 1, '{0, 0, 16384, 0, 0});
        // argument not positive: clamped to one LSB, s = 128, z = 64
        add_row(diag_matrix(16384, 16384, -32768), 1, '{0, 0, 64, 0, 1});
        add_row(diag_matrix(0, 0, -32768), 1, '{0, 0, 64, 0, 1});
        // ties fall to the z branch
        add_row(diag_matrix(-100, -100, -100), 0, '0);
        add_row(diag_matrix(0, 0, -5), 0, '0);
        add_row(diag_matrix(-5, 0, 0), 0, '0);
        // extremes of every element
        add_row({9{16'sh7fff}}, 0, '0);
        add_row({9{16'sh8000}}, 0, '0);
        add_row({16'sh7fff, {4{16'sh8000, 16'sh7fff}}}, 0, '0);
        // small root with large differences: off-diagonal saturation
        m = diag_matrix(16384, 16384, -32768);
        m.xy = 16'sh7fff; m.yx = 16'sh7fff; m.xz = 16'sh8000; m.zx = 16'sh8000;
        m.yz = 16'sh7fff; m.zy = 16'sh8000;
        add_row(m, 0, '0);
        m.xx = 16'sh7fff;
        add_row(m, 0, '0);
        m = diag_matrix(-32768, 100, -32768);
        m.xy = 16'sh7fff; m.zy = 16'sh7fff; m.yz = 16'sh7fff; m.xz = 16'sh8000;
        add_row(m, 0, '0);
        // trace branch with large skew parts
        m = diag_matrix(1, 0, 0);
        m.zy = 16'sh7fff; m.yz = 16'sh8000; m.xz = 16'sh7fff; m.zx = 16'sh8000;
        m.yx = 16'sh8000; m.xy = 16'sh7fff;
        add_row(m, 0, '0);
        for (int i = 0; i < 6; i++)
            add_row(rand_rotation(), 0, '0);
    endtask

    // --- sender -------------------------------------------------------------

    task automatic send_word(matrix_t m);
        {x_axis_x, x_axis_y, x_axis_z, y_axis_x, y_axis_y, y_axis_z,
         z_axis_x, z_axis_y, z_axis_z} <= m;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic sender_gap();
        int n;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            n = $urandom_range(1, 17);
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    initial
    begin
        stim_row_t r;
        matrix_t m;
        quat_t q;
        in_valid = 1'b0;
        {x_axis_x, x_axis_y, x_axis_z, y_axis_x, y_axis_y, y_axis_z,
         z_axis_x, z_axis_y, z_axis_z} = '0;
        rst_n = 1'b0;
        sender_done = 1'b0;
        calm = 1'b0;
        hold_off = 1'b0;
        fail_count = 0;
        words_checked = 0;
        build_table();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            r = dir_rows[i];
            q = predict_quat(r.m);
            if (r.known && q != r.q)
            begin
                $display("%0t: table row %0d predictor mismatch exp %h got %h",
                         $time, i, r.q, q);
                fail_count++;
            end
            quat_expected.push_back(r.known ? r.q : q);
            send_word(r.m);
            sender_gap();
        end

        for (int i = 0; i < NumRandom; i++)
        begin
            if (i == 150)
                hold_off = 1'b1;
            if (i == NumRandom - 120)
                calm = 1'b1;
            if ($urandom_range(0, 3) != 0)
                m = rand_rotation();
            else
                m = {rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
                     rand_elem(), rand_elem(), rand_elem(), rand_elem()};
            quat_expected.push_back(predict_quat(m));
            send_word(m);
            sender_gap();
        end
        in_valid <= 1'b0;
        sender_done = 1'b1;
    end

    // --- receiver -------------------------------------------------------------

    initial
    begin
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                // long hold-off so the pipeline fills and stalls its input
                hold_off = 1'b0;
                out_stall <= 1'b1;
                repeat (60) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 17);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // --- output check -----------------------------------------------------------

    always @(posedge clk)
    begin
        quat_t got, exp_q;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{quat_x, quat_y, quat_z, quat_w, saturated};
            if (quat_expected.size() == 0)
            begin
                $display("%0t: unexpected word %h", $time, got);
                fail_count++;
            end
            else
            begin
                exp_q = quat_expected.pop_front();
                words_checked++;
                if (got.qx !== exp_q.qx)
                    $display("%0t: quat_x exp %0d got %0d", $time, exp_q.qx, got.qx);
                if (got.qy !== exp_q.qy)
                    $display("%0t: quat_y exp %0d got %0d", $time, exp_q.qy, got.qy);
                if (got.qz !== exp_q.qz)
                    $display("%0t: quat_z exp %0d got %0d", $time, exp_q.qz, got.qz);
                if (got.qw !== exp_q.qw)
                    $display("%0t: quat_w exp %0d got %0d", $time, exp_q.qw, got.qw);
                if (got.sat !== exp_q.sat)
                    $display("%0t: saturated exp %0b got %0b", $time, exp_q.sat, got.sat);
                if (got !== exp_q)
                    fail_count++;
            end
        end
    end

    // --- end of run -------------------------------------------------------------

    initial
    begin
        wait (sender_done);
        while (quat_expected.size() != 0)
            @(posedge clk);
        repeat (TailCycles) @(posedge clk);
        $display("Covered %0d words: directed table, near-rotations and raw patterns,",
                 words_checked);
        $display("with random idling on both channels and one long output hold-off.");
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("Timeout");
        $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
design/rmq_pkg.sv
design/rmq_front.sv
design/rmq_sqrt.sv
design/rmq_div.sv
design/rotation_matrix_to_quaternion.sv
sim/tb.sv
